FILE: src/fcr_pkg.sv
// ----------------------------------------------------------------------------
// fcr_pkg
// shared codes, widths and types of the int8 fully connected relu layer
// ----------------------------------------------------------------------------
package fcr_pkg;

  localparam int DATA_W    = 8;
  localparam int PROD_W    = 16;
  localparam int ACC_W     = 24;
  localparam int RES_W     = 23;
  localparam int IN_LEN_W  = 11;
  localparam int OUT_LEN_W = 8;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  // access kinds
  localparam logic [1:0] FUNC_SOURCE = 2'd0;
  localparam logic [1:0] FUNC_WEIGHT = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_INPUT_LENGTH  = 1'b0;
  localparam logic REG_OUTPUT_LENGTH = 1'b1;

  localparam logic [IN_LEN_W-1:0]  INPUT_LENGTH_RST  = 11'd400;
  localparam logic [OUT_LEN_W-1:0] OUTPUT_LENGTH_RST = 8'd120;

  typedef enum logic [2:0] {
    PH_SOURCE = 3'b001,
    PH_WEIGHT = 3'b010,
    PH_RESULT = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    OP_MAC    = 2'd0,
    OP_RESULT = 2'd1,
    OP_EMPTY  = 2'd2
  } op_t;

  // decoded item handed from the sequencer to the accumulator stage
  typedef struct packed {
    logic                     vld;
    op_t                      op;
    logic                     first_row;
    logic                     last;
    logic signed [PROD_W-1:0] prod;
  } stage_t;

  function automatic logic signed [DATA_W-1:0] to_s8(input logic [DATA_W-1:0] d,
                                                     input logic [DATA_W-1:0] en);
    return d & en;
  endfunction

endpackage

FILE: src/fully_connected_relu_layer.sv
// ----------------------------------------------------------------------------
// fully_connected_relu_layer
// int8 fully connected layer with relu, fed by source, weight and read items
// ----------------------------------------------------------------------------
//   port group    direction  handshake          contents
//   item in       in         in_valid/in_stall  func, data_byte, byte_enable
//   result out    out        out_valid/out_stall result_value, valid_res, last
//   config        in/out     apb psel/penable   input_length @0, output_length @4
//
// one item per cycle; an item passes the input register, the decode and
// multiply stage and the accumulator ram stage, then the result register.
// the accumulator ram has one registered read port, a write in the same
// cycle to the same entry is forwarded. a stalled result freezes all
// stages. reset is synchronous and needs no clearing pass: the first row
// of each pass overwrites the accumulators.
// ----------------------------------------------------------------------------
module fully_connected_relu_layer #(
  parameter int MAX_OUTPUTS = 128,
  parameter int MAX_INPUTS  = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     func,
  input  logic [fcr_pkg::DATA_W-1:0]     data_byte,
  input  logic [fcr_pkg::DATA_W-1:0]     byte_enable,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fcr_pkg::RES_W-1:0]      result_value,
  output logic                           valid_res,
  output logic                           last,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fcr_pkg::APB_AW-1:0]     paddr,
  input  logic [fcr_pkg::APB_DW-1:0]     pwdata,
  output logic [fcr_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);

  localparam int CW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

  logic [fcr_pkg::IN_LEN_W-1:0]  input_length;
  logic [fcr_pkg::OUT_LEN_W-1:0] output_length;
  logic                          cfg_wr;
  logic                          adv;
  fcr_pkg::stage_t               stage;
  logic [CW-1:0]                 idx;

  assign in_stall = !adv;

  fcr_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .input_length  (input_length),
    .output_length (output_length),
    .cfg_wr        (cfg_wr)
  );

  fcr_seq #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .in_valid      (in_valid),
    .func          (func),
    .data_byte     (data_byte),
    .byte_enable   (byte_enable),
    .input_length  (input_length),
    .output_length (output_length),
    .cfg_wr        (cfg_wr),
    .stage         (stage),
    .idx           (idx)
  );

  fcr_acc #(
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_acc (
    .clk          (clk),
    .rst          (rst),
    .stage        (stage),
    .idx          (idx),
    .out_stall    (out_stall),
    .adv          (adv),
    .out_valid    (out_valid),
    .result_value (result_value),
    .valid_res    (valid_res),
    .last         (last)
  );

endmodule

FILE: src/fcr_ram.sv
// ----------------------------------------------------------------------------
// fcr_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module fcr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/fcr_cfg.sv
// ----------------------------------------------------------------------------
// fcr_cfg
// apb register file holding the two length registers
// ----------------------------------------------------------------------------
module fcr_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fcr_pkg::APB_AW-1:0]          paddr,
  input  logic [fcr_pkg::APB_DW-1:0]          pwdata,
  output logic [fcr_pkg::APB_DW-1:0]          prdata,
  output logic                                pready,
  output logic [fcr_pkg::IN_LEN_W-1:0]        input_length,
  output logic [fcr_pkg::OUT_LEN_W-1:0]       output_length,
  output logic                                cfg_wr
);

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_length  <= fcr_pkg::INPUT_LENGTH_RST;
      output_length <= fcr_pkg::OUTPUT_LENGTH_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == fcr_pkg::REG_INPUT_LENGTH) begin
        input_length <= pwdata[fcr_pkg::IN_LEN_W-1:0];
      end else begin
        output_length <= pwdata[fcr_pkg::OUT_LEN_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == fcr_pkg::REG_OUTPUT_LENGTH) begin
      prdata = fcr_pkg::APB_DW'(output_length);
    end else begin
      prdata = fcr_pkg::APB_DW'(input_length);
    end
  end

endmodule

FILE: src/fcr_seq.sv
// ----------------------------------------------------------------------------
// fcr_seq
// input register, phase tracking, row and column counts and the multiplier
// ----------------------------------------------------------------------------
module fcr_seq #(
  parameter int MAX_INPUTS  = 1024,
  parameter int MAX_OUTPUTS = 128
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        adv,
  input  logic                                        in_valid,
  input  logic [1:0]                                  func,
  input  logic [fcr_pkg::DATA_W-1:0]                  data_byte,
  input  logic [fcr_pkg::DATA_W-1:0]                  byte_enable,
  input  logic [fcr_pkg::IN_LEN_W-1:0]                input_length,
  input  logic [fcr_pkg::OUT_LEN_W-1:0]               output_length,
  input  logic                                        cfg_wr,
  output fcr_pkg::stage_t                             stage,
  output logic [(MAX_OUTPUTS > 1 ? $clog2(MAX_OUTPUTS) : 1)-1:0] idx
);

  localparam int CW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int OLW = $clog2(MAX_OUTPUTS + 1);
  localparam int RW  = $clog2(MAX_INPUTS + 1);

  // input register
  logic                        ireg_vld;
  logic [1:0]                  ireg_func;
  logic [fcr_pkg::DATA_W-1:0]  ireg_data;
  logic [fcr_pkg::DATA_W-1:0]  ireg_en;

  fcr_pkg::phase_t                   phase, phase_next;
  logic [RW-1:0]                     row, row_next;
  logic [CW-1:0]                     col, col_next;
  logic signed [fcr_pkg::DATA_W-1:0] held, held_next;

  logic [RW-1:0]                     rows_eff;
  logic [OLW-1:0]                    cols_eff;
  logic                              row_end;
  logic                              col_end;
  logic signed [fcr_pkg::DATA_W-1:0] item_s8;

  // length registers clipped to the supported range, zero acts as one
  always_comb begin
    if (input_length == '0) begin
      rows_eff = RW'(1);
    end else if (32'(input_length) > 32'(MAX_INPUTS)) begin
      rows_eff = RW'(MAX_INPUTS);
    end else begin
      rows_eff = RW'(input_length);
    end
    if (output_length == '0) begin
      cols_eff = OLW'(1);
    end else if (32'(output_length) > 32'(MAX_OUTPUTS)) begin
      cols_eff = OLW'(MAX_OUTPUTS);
    end else begin
      cols_eff = OLW'(output_length);
    end
  end

  assign row_end = (32'(row) + 32'd1) >= 32'(rows_eff);
  assign col_end = (32'(col) + 32'd1) >= 32'(cols_eff);
  assign item_s8 = fcr_pkg::to_s8(ireg_data, ireg_en);
  assign idx     = col;

  always_comb begin
    phase_next      = phase;
    row_next        = row;
    col_next        = col;
    held_next       = held;
    stage.vld       = 1'b0;
    stage.op        = fcr_pkg::OP_EMPTY;
    stage.first_row = 1'b0;
    stage.last      = 1'b0;
    stage.prod      = fcr_pkg::PROD_W'(held) * fcr_pkg::PROD_W'(item_s8);
    if (ireg_vld) begin
      case (ireg_func)
        fcr_pkg::FUNC_SOURCE: begin
          if (phase == fcr_pkg::PH_SOURCE) begin
            held_next  = item_s8;
            col_next   = '0;
            phase_next = fcr_pkg::PH_WEIGHT;
          end
        end
        fcr_pkg::FUNC_WEIGHT: begin
          if (phase == fcr_pkg::PH_WEIGHT) begin
            stage.vld       = 1'b1;
            stage.op        = fcr_pkg::OP_MAC;
            // first row of a pass starts from zero instead of the stored sum
            stage.first_row = (row == '0);
            if (col_end) begin
              col_next = '0;
              if (row_end) begin
                row_next   = '0;
                phase_next = fcr_pkg::PH_RESULT;
              end else begin
                row_next   = row + RW'(1);
                phase_next = fcr_pkg::PH_SOURCE;
              end
            end else begin
              col_next = col + CW'(1);
            end
          end
        end
        fcr_pkg::FUNC_READ: begin
          stage.vld = 1'b1;
          if (phase == fcr_pkg::PH_RESULT) begin
            stage.op   = fcr_pkg::OP_RESULT;
            stage.last = col_end;
            if (col_end) begin
              col_next   = '0;
              row_next   = '0;
              phase_next = fcr_pkg::PH_SOURCE;
            end else begin
              col_next = col + CW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_vld <= 1'b0;
    end else if (adv) begin
      ireg_vld <= in_valid;
    end
    if (adv && in_valid) begin
      ireg_func <= func;
      ireg_data <= data_byte;
      ireg_en   <= byte_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= fcr_pkg::PH_SOURCE;
      row   <= '0;
      col   <= '0;
      held  <= '0;
    end else if (cfg_wr) begin
      // a register write abandons the pass in progress
      phase <= fcr_pkg::PH_SOURCE;
      row   <= '0;
      col   <= '0;
    end else if (adv) begin
      phase <= phase_next;
      row   <= row_next;
      col   <= col_next;
      held  <= held_next;
    end
  end

endmodule

FILE: src/fcr_acc.sv
// ----------------------------------------------------------------------------
// fcr_acc
// accumulator memory read-modify-write, relu clamp and result register
// ----------------------------------------------------------------------------
module fcr_acc #(
  parameter int MAX_OUTPUTS = 128
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  fcr_pkg::stage_t                             stage,
  input  logic [(MAX_OUTPUTS > 1 ? $clog2(MAX_OUTPUTS) : 1)-1:0] idx,
  input  logic                                        out_stall,
  output logic                                        adv,
  output logic                                        out_valid,
  output logic [fcr_pkg::RES_W-1:0]                   result_value,
  output logic                                        valid_res,
  output logic                                        last
);

  localparam int CW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

  fcr_pkg::stage_t            m;
  logic [CW-1:0]              m_idx;
  logic [fcr_pkg::ACC_W-1:0]  ram_q;
  logic                       byp_hit;
  logic [fcr_pkg::ACC_W-1:0]  byp_data;
  logic [fcr_pkg::ACC_W-1:0]  acc_cur;
  logic [fcr_pkg::ACC_W-1:0]  acc_old;
  logic [fcr_pkg::ACC_W-1:0]  sum;
  logic                       wr_en;

  // the whole pipe holds while a result waits and the sink stalls
  assign adv = !(out_valid && out_stall);

  fcr_ram #(
    .WIDTH (fcr_pkg::ACC_W),
    .DEPTH (MAX_OUTPUTS)
  ) u_acc_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (m_idx),
    .wdata (sum),
    .re    (adv),
    .raddr (idx),
    .rdata (ram_q)
  );

  // ram reads old data when the same entry is written in the same cycle
  assign acc_cur = byp_hit ? byp_data : ram_q;
  assign acc_old = m.first_row ? '0 : acc_cur;
  assign sum     = acc_old + {{(fcr_pkg::ACC_W - fcr_pkg::PROD_W){m.prod[fcr_pkg::PROD_W-1]}},
                              m.prod};
  assign wr_en   = adv && m.vld && (m.op == fcr_pkg::OP_MAC);

  always_ff @(posedge clk) begin
    if (rst) begin
      m.vld <= 1'b0;
    end else if (adv) begin
      m <= stage;
    end
    if (adv) begin
      m_idx    <= idx;
      byp_hit  <= wr_en && (m_idx == idx);
      byp_data <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= m.vld && (m.op != fcr_pkg::OP_MAC);
    end
    if (adv && m.vld) begin
      case (m.op)
        fcr_pkg::OP_RESULT: begin
          // relu: negative sums read as zero
          result_value <= acc_cur[fcr_pkg::ACC_W-1] ? '0 : acc_cur[fcr_pkg::RES_W-1:0];
          valid_res    <= 1'b1;
          last         <= m.last;
        end
        fcr_pkg::OP_EMPTY: begin
          result_value <= '0;
          valid_res    <= 1'b0;
          last         <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
